// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the site update top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/ims_pkg.sv =====
// Types and constants for the Ising Metropolis site update block.
`default_nettype none
package ims_pkg;

  localparam int COORD_W    = 5;
  localparam int FRAC_W     = 32;
  localparam int DE_W       = 5;
  localparam int ENERGY_W   = 13;
  localparam int MAG_W      = 12;
  localparam int CFG_ADDR_W = 1;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // action codes
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_SET    = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH_FOUR  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESH_EIGHT = 1'b1;

  // spins around one site, 1 = +1
  typedef struct packed {
    logic center;
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_t;

endpackage
`default_nettype wire

// ===== rtl/core/ims_lattice.sv =====
// Spin lattice in flops: reads a site and its four wrapped neighbours, writes one site.
`default_nettype none
module ims_lattice #(
  parameter int LATTICE_SIDE = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [$clog2(LATTICE_SIDE)-1:0]   rd_row,
  input  wire logic [$clog2(LATTICE_SIDE)-1:0]   rd_col,
  output ims_pkg::nbr_t                          spins,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(LATTICE_SIDE)-1:0]   wr_row,
  input  wire logic [$clog2(LATTICE_SIDE)-1:0]   wr_col,
  input  wire logic                              wr_spin
);
  import ims_pkg::*;

  localparam int IW = $clog2(LATTICE_SIDE);
  localparam logic [IW-1:0] LAST = IW'(LATTICE_SIDE - 1);

  logic [LATTICE_SIDE-1:0] lat_r [LATTICE_SIDE];

  logic [IW-1:0] up_row, dn_row, lf_col, rt_col;
  logic [LATTICE_SIDE-1:0] row_up, row_mid, row_dn;

  // periodic wrap
  always_comb begin
    up_row = (rd_row == '0)   ? LAST : rd_row - IW'(1);
    dn_row = (rd_row == LAST) ? '0   : rd_row + IW'(1);
    lf_col = (rd_col == '0)   ? LAST : rd_col - IW'(1);
    rt_col = (rd_col == LAST) ? '0   : rd_col + IW'(1);
  end

  always_comb begin
    row_up  = lat_r[up_row];
    row_mid = lat_r[rd_row];
    row_dn  = lat_r[dn_row];
    spins.center = row_mid[rd_col];
    spins.up     = row_up[rd_col];
    spins.dn     = row_dn[rd_col];
    spins.lf     = row_mid[lf_col];
    spins.rt     = row_mid[rt_col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATTICE_SIDE; i++) begin
        lat_r[i] <= '1;
      end
    end else if (wr_en) begin
      lat_r[wr_row][wr_col] <= wr_spin;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ising_metropolis_site_update.sv =====
// Top level of the Ising Metropolis site update block.
//
// Keeps a periodic LATTICE_SIDE x LATTICE_SIDE lattice of spins (J = 1, no field)
// with running totals of lattice energy and magnetization. An update item
// (tuser = 0) names a site and brings a uniform 0.32 random fraction; the site
// flips when the flip energy change dE is 0 or negative, or when the random
// fraction is below the threshold register for dE = +4 or dE = +8. A set item
// (tuser = 1) forces the site to spin_value. Row and col are taken modulo
// LATTICE_SIDE. Every item gives exactly one result: flipped, dE judged on the
// lattice before the item, totals and site spin after it. Totals wrap in two's
// complement at their field widths.
// Rate: one item per clock, sustained while out_tready stays high. An item sits
// in the input register until the result register is free; there the lattice
// read, the dE and accept decision, the lattice write and the totals add all
// complete. The next item in that register sees the updated lattice, so
// back-to-back items on neighbouring sites are exact. out_tvalid is registered
// and rises as an item moves into the result register. A result held by out_tready
// low keeps the item behind it waiting, and in_tready drops while both registers
// are full and out_tready is low. The lattice lives in flops and is set to all +1
// by reset; there is no clearing pass. Threshold registers are written through
// cfg_* while no item is in flight; the user must ensure it, the block does not.
`default_nettype none
`include "assert_macros.svh"
module ising_metropolis_site_update #(
  parameter int LATTICE_SIDE = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // input items
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [4:0] row, [9:5] col, [10] spin_value, [42:11] random_fraction, [47:43] zero
  input  wire logic [ims_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] action
  input  wire logic                                 in_tuser,
  // result items
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [0] flipped, [5:1] delta_energy, [18:6] total_energy,
  // [30:19] magnetization, [31] new_spin
  output logic [ims_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // configuration writes
  input  wire logic                                 cfg_we,
  input  wire logic [ims_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [ims_pkg::FRAC_W-1:0]           cfg_wdata
);
  import ims_pkg::*;

  localparam int IW        = $clog2(LATTICE_SIDE);
  localparam int SITES     = LATTICE_SIDE * LATTICE_SIDE;
  localparam int COORD_N   = 2 ** COORD_W;
  localparam logic [ENERGY_W-1:0] ENERGY_RST = ENERGY_W'(-2 * SITES);
  localparam logic [MAG_W-1:0]    MAG_RST    = MAG_W'(SITES);
  localparam logic [FRAC_W-1:0]   TH4_RST    = 32'd1477011920;
  localparam logic [FRAC_W-1:0]   TH8_RST    = 32'd507938990;

  // ---- coordinate wrap table (row, col mod LATTICE_SIDE) ----
  logic [IW-1:0] wrap_tab [COORD_N];
  for (genvar k = 0; k < COORD_N; k++) begin : g_wrap
    assign wrap_tab[k] = IW'(k % LATTICE_SIDE);
  end

  // ---- configuration ----
  logic [FRAC_W-1:0] th4_r, th8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th4_r <= TH4_RST;
      th8_r <= TH8_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESH_FOUR:  th4_r <= cfg_wdata;
        REG_THRESH_EIGHT: th8_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- input register ----
  logic              s1_vld_r, s1_vld_nxt;
  logic              s1_act_r;
  logic [IW-1:0]     s1_row_r, s1_col_r;
  logic              s1_want_r;
  logic [FRAC_W-1:0] s1_rnd_r;
  logic              in_acc;
  logic              advance;
  logic              out_vld_r, out_vld_nxt;

  assign advance   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_act_r  <= in_tuser;
      s1_row_r  <= wrap_tab[in_tdata[4:0]];
      s1_col_r  <= wrap_tab[in_tdata[9:5]];
      s1_want_r <= in_tdata[10];
      s1_rnd_r  <= in_tdata[42:11];
    end
  end

  // ---- lattice ----
  nbr_t nbr;
  logic flip;
  logic new_spin;

  ims_lattice #(
    .LATTICE_SIDE(LATTICE_SIDE)
  ) u_lattice (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_row  (s1_row_r),
    .rd_col  (s1_col_r),
    .spins   (nbr),
    .wr_en   (advance && flip),
    .wr_row  (s1_row_r),
    .wr_col  (s1_col_r),
    .wr_spin (new_spin)
  );

  // ---- flip energy and accept decision ----
  // neighbours at +1 count k: sum = 2k - 4, dE = 2*s*sum = s*(4k - 8)
  logic [2:0]            up_cnt;
  logic signed [5:0]     de_pos;
  logic signed [DE_W-1:0] de;

  always_comb begin
    up_cnt = 3'(nbr.up) + 3'(nbr.dn) + 3'(nbr.lf) + 3'(nbr.rt);
    de_pos = $signed({1'b0, up_cnt, 2'b00}) - 6'sd8;
    de     = nbr.center ? de_pos[DE_W-1:0] : DE_W'(-de_pos);
  end

  always_comb begin
    case (s1_act_r)
      ACT_UPDATE: begin
        if (de[DE_W-1] || de == '0) begin
          flip = 1'b1;
        end else if (de == DE_W'(4)) begin
          flip = s1_rnd_r < th4_r;
        end else begin
          flip = s1_rnd_r < th8_r;
        end
      end
      ACT_SET: flip = s1_want_r != nbr.center;
      default: flip = 1'b0;
    endcase
    new_spin = nbr.center ^ flip;
  end

  // ---- running totals ----
  logic [ENERGY_W-1:0] energy_r, energy_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;

  always_comb begin
    energy_nxt = energy_r;
    mag_nxt    = mag_r;
    if (advance && flip) begin
      energy_nxt = energy_r + {{(ENERGY_W-DE_W){de[DE_W-1]}}, de};
      mag_nxt    = new_spin ? mag_r + MAG_W'(2) : mag_r - MAG_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= ENERGY_RST;
      mag_r    <= MAG_RST;
    end else begin
      energy_r <= energy_nxt;
      mag_r    <= mag_nxt;
    end
  end

  // ---- result register ----
  logic                out_flip_r;
  logic [DE_W-1:0]     out_de_r;
  logic [ENERGY_W-1:0] out_energy_r;
  logic [MAG_W-1:0]    out_mag_r;
  logic                out_spin_r;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flip_r   <= flip;
      out_de_r     <= de;
      out_energy_r <= energy_nxt;
      out_mag_r    <= mag_nxt;
      out_spin_r   <= new_spin;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_spin_r, out_mag_r, out_energy_r, out_de_r, out_flip_r};

  // ---- checks ----
  // every flip moves energy by a multiple of 4 and magnetization by 2
  `ASSERT_CLKRST(a_energy_mod4, clk, rst_n, energy_r[1:0] == ENERGY_RST[1:0], "energy total left its residue class mod 4")
  `ASSERT_CLKRST(a_mag_parity, clk, rst_n, mag_r[0] == MAG_RST[0], "magnetization parity changed")
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_tready, s1_vld_r && out_vld_r && !out_tready, "input stalled without a blocked result")
  `ASSERT_IMPL(a_totals_hold, clk, rst_n, !advance, (energy_nxt == energy_r) && (mag_nxt == mag_r), "totals moved without an item")

endmodule
`default_nettype wire
